### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define CSD_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Overlapping implication.
`define CSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/csd_pkg.sv
// Package for the capped cylinder signed distance block.
// Register indexes, field widths and reset values. No dependencies.
`timescale 1ns / 1ps
package csd_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned ColW   = 54;
	localparam int unsigned EntW   = 18;
	localparam int unsigned LenW   = 31;
	localparam int unsigned IdxW   = 3;

	typedef enum logic [IdxW-1:0] {
		REG_CENTRE_X   = 3'd0,
		REG_CENTRE_Y   = 3'd1,
		REG_CENTRE_Z   = 3'd2,
		REG_AXIS_COL_X = 3'd3,
		REG_AXIS_COL_Y = 3'd4,
		REG_AXIS_COL_Z = 3'd5,
		REG_CYL_RADIUS = 3'd6,
		REG_CYL_HEIGHT = 3'd7
	} reg_idx_t;

	localparam logic [ColW-1:0] ColXReset = 54'd65536;
	localparam logic [ColW-1:0] ColYReset = 54'd65536 << 18;
	localparam logic [ColW-1:0] ColZReset = 54'd65536 << 36;
	localparam logic [LenW-1:0] LenReset  = 31'd65536;

endpackage

### hw/rtl/csd_sqrt.sv
// Pipelined integer square root, one root bit per stage, rounded to nearest.
// Carries a sideband word alongside. Uses no package.
`timescale 1ns / 1ps
module csd_sqrt #(
	parameter int unsigned W  = 64,
	parameter int unsigned SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [W-1:0]      rad,
	input  logic [SW-1:0]     side_in,
	output logic              out_vld,
	output logic [W/2:0]      root,
	output logic [SW-1:0]     side_out
);
	localparam int unsigned N  = W / 2;
	localparam int unsigned RW = N + 3;

	logic [RW-1:0] rem_q  [0:N];
	logic [N-1:0]  root_q [0:N];
	logic [W-1:0]  rad_q  [0:N];
	logic [SW-1:0] side_q [0:N];
	logic          vld_q  [0:N];
	logic          rnd;

	assign rem_q[0]  = '0;
	assign root_q[0] = '0;
	assign rad_q[0]  = rad;
	assign side_q[0] = side_in;
	assign vld_q[0]  = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		assign rem_sh = {rem_q[k][RW-3:0], rad_q[k][W-1:W-2]};
		assign trial  = {1'b0, root_q[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vld_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_sh >= trial) begin
				rem_q[k+1]  <= rem_sh - trial;
				root_q[k+1] <= {root_q[k][N-2:0], 1'b1};
			end else begin
				rem_q[k+1]  <= rem_sh;
				root_q[k+1] <= {root_q[k][N-2:0], 1'b0};
			end
			rad_q[k+1]  <= {rad_q[k][W-3:0], 2'b00};
			side_q[k+1] <= side_q[k];
		end
	end

	assign rnd = rem_q[N] > {3'b000, root_q[N]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_q[N];
		end
	end

	always_ff @(posedge clk) begin
		root     <= {1'b0, root_q[N]} + {{N{1'b0}}, rnd};
		side_out <= side_q[N];
	end

endmodule

### hw/rtl/csd_xform.sv
// World to cylinder frame: centre subtract, 3x3 products, sum, round, clamp.
// Three register stages. Depends on csd_pkg.
`timescale 1ns / 1ps
module csd_xform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [csd_pkg::CoordW-1:0]   px,
	input  logic signed [csd_pkg::CoordW-1:0]   py,
	input  logic signed [csd_pkg::CoordW-1:0]   pz,
	input  logic signed [csd_pkg::CoordW-1:0]   cx,
	input  logic signed [csd_pkg::CoordW-1:0]   cy,
	input  logic signed [csd_pkg::CoordW-1:0]   cz,
	input  logic [csd_pkg::ColW-1:0]            col_x,
	input  logic [csd_pkg::ColW-1:0]            col_y,
	input  logic [csd_pkg::ColW-1:0]            col_z,
	output logic                                out_vld,
	output logic signed [csd_pkg::CoordW-1:0]   lx,
	output logic signed [csd_pkg::CoordW-1:0]   ly,
	output logic signed [csd_pkg::CoordW-1:0]   lz,
	output logic                                sat
);
	logic signed [32:0] d_s1 [3];
	logic               vld_s1, vld_s2;
	logic signed [50:0] prod_s2 [3][3];
	logic signed [50:0] prod [3][3];
	logic [csd_pkg::ColW-1:0] cols [3];
	logic signed [31:0] loc [3];
	logic [2:0]         clip;

	assign cols[0] = col_x;
	assign cols[1] = col_y;
	assign cols[2] = col_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= 33'(px) - 33'(cx);
		d_s1[1] <= 33'(py) - 33'(cy);
		d_s1[2] <= 33'(pz) - 33'(cz);
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				prod[c][i] = 51'(d_s1[i]) * 51'($signed(cols[c][18*i +: 18]));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
	end

	always_comb begin
		logic signed [53:0] t;
		logic signed [37:0] q;
		for (int c = 0; c < 3; c++) begin
			t = 54'(prod_s2[c][0]) + 54'(prod_s2[c][1]) + 54'(prod_s2[c][2])
				+ 54'sd32768;
			q = 38'(t >>> 16);
			if (q > 38'sd2147483647) begin
				loc[c]  = 32'sh7FFFFFFF;
				clip[c] = 1'b1;
			end else if (q < -38'sd2147483648) begin
				loc[c]  = 32'sh80000000;
				clip[c] = 1'b1;
			end else begin
				loc[c]  = q[31:0];
				clip[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lx  <= loc[0];
		ly  <= loc[1];
		lz  <= loc[2];
		sat <= |clip;
	end

endmodule

### hw/rtl/cylinder_signed_distance_top.sv
// Capped cylinder signed distance, top level: config registers and pipeline.
// Depends on csd_pkg, csd_xform, csd_sqrt.
//
//  channel | handshake                 | payload
//  input   | start (busy held low)     | point_x, point_y, point_z
//  result  | done strobe, one cycle    | distance, corner_region, saturated
//  config  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One point enters per cycle; a new point can enter before earlier results have left.
// Most stages lie in the two bit-per-stage square root pipelines (33 and 34 stages).
// Reset clears valid bits and loads config defaults; results cannot be stalled.
`timescale 1ns / 1ps
module cylinder_signed_distance_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [csd_pkg::CoordW-1:0]  point_x,
	input  logic signed [csd_pkg::CoordW-1:0]  point_y,
	input  logic signed [csd_pkg::CoordW-1:0]  point_z,
	output logic                               done,
	output logic signed [csd_pkg::CoordW-1:0]  distance,
	output logic                               corner_region,
	output logic                               saturated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csd_pkg::IdxW-1:0]           cfg_index,
	input  logic [csd_pkg::ColW-1:0]           cfg_data
);
	logic signed [31:0] centre_x_q, centre_y_q, centre_z_q;
	logic [csd_pkg::ColW-1:0] col_x_q, col_y_q, col_z_q;
	logic [csd_pkg::LenW-1:0] radius_q, height_q;

	logic               x_vld, x_sat;
	logic signed [31:0] lx, ly, lz;

	logic               vld_s4, sat_s4;
	logic [63:0]        sqx_s4, sqy_s4;
	logic signed [33:0] dz_s4;
	logic [31:0]        az;

	logic               vld_s5;
	logic [63:0]        sum_s5;
	logic [34:0]        side_s5;

	logic               r1_vld;
	logic [32:0]        r1_root;
	logic [34:0]        r1_side;
	logic signed [33:0] dr, dz_r1;

	logic               vld_s6, corner_s6, sat_s6;
	logic [31:0]        dr_s6, dz_s6;
	logic signed [33:0] max_s6;

	logic               vld_s7, corner_s7, sat_s7;
	logic [63:0]        sqr_s7, sqz_s7;
	logic signed [33:0] max_s7;

	logic               vld_s8;
	logic [65:0]        sum_s8;
	logic [35:0]        side_s8;

	logic               r2_vld;
	logic [33:0]        r2_root;
	logic [35:0]        r2_side;
	logic signed [34:0] res;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q <= '0;
			centre_y_q <= '0;
			centre_z_q <= '0;
			col_x_q    <= csd_pkg::ColXReset;
			col_y_q    <= csd_pkg::ColYReset;
			col_z_q    <= csd_pkg::ColZReset;
			radius_q   <= csd_pkg::LenReset;
			height_q   <= csd_pkg::LenReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (csd_pkg::reg_idx_t'(cfg_index))
				csd_pkg::REG_CENTRE_X:   centre_x_q <= cfg_data[31:0];
				csd_pkg::REG_CENTRE_Y:   centre_y_q <= cfg_data[31:0];
				csd_pkg::REG_CENTRE_Z:   centre_z_q <= cfg_data[31:0];
				csd_pkg::REG_AXIS_COL_X: col_x_q    <= cfg_data;
				csd_pkg::REG_AXIS_COL_Y: col_y_q    <= cfg_data;
				csd_pkg::REG_AXIS_COL_Z: col_z_q    <= cfg_data;
				csd_pkg::REG_CYL_RADIUS: radius_q   <= cfg_data[30:0];
				csd_pkg::REG_CYL_HEIGHT: height_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	csd_xform u_xform (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.px      (point_x),
		.py      (point_y),
		.pz      (point_z),
		.cx      (centre_x_q),
		.cy      (centre_y_q),
		.cz      (centre_z_q),
		.col_x   (col_x_q),
		.col_y   (col_y_q),
		.col_z   (col_z_q),
		.out_vld (x_vld),
		.lx      (lx),
		.ly      (ly),
		.lz      (lz),
		.sat     (x_sat)
	);

	assign az = lz[31] ? 32'(-33'(lz)) : 32'(lz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s4 <= x_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= r1_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			done   <= r2_vld;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s4 <= 64'(64'(lx) * 64'(lx));
		sqy_s4 <= 64'(64'(ly) * 64'(ly));
		dz_s4  <= $signed({2'b00, az}) - $signed({4'b0000, height_q[30:1]});
		sat_s4 <= x_sat;
		sum_s5  <= sqx_s4 + sqy_s4;
		side_s5 <= {dz_s4, sat_s4};
	end

	csd_sqrt #(.W(64), .SW(35)) u_sqrt_rad (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.rad      (sum_s5),
		.side_in  (side_s5),
		.out_vld  (r1_vld),
		.root     (r1_root),
		.side_out (r1_side)
	);

	assign dz_r1 = r1_side[34:1];
	assign dr    = $signed({1'b0, r1_root}) - $signed({3'b000, radius_q});

	always_ff @(posedge clk) begin
		dr_s6     <= dr[31:0];
		dz_s6     <= dz_r1[31:0];
		corner_s6 <= (dr > 34'sd0) && (dz_r1 > 34'sd0);
		max_s6    <= (dr > dz_r1) ? dr : dz_r1;
		sat_s6    <= r1_side[0];
		sqr_s7    <= 64'(dr_s6) * 64'(dr_s6);
		sqz_s7    <= 64'(dz_s6) * 64'(dz_s6);
		corner_s7 <= corner_s6;
		max_s7    <= max_s6;
		sat_s7    <= sat_s6;
		sum_s8    <= 66'(sqr_s7) + 66'(sqz_s7);
		side_s8   <= {corner_s7, max_s7, sat_s7};
	end

	csd_sqrt #(.W(66), .SW(36)) u_sqrt_corner (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.rad      (sum_s8),
		.side_in  (side_s8),
		.out_vld  (r2_vld),
		.root     (r2_root),
		.side_out (r2_side)
	);

	assign res = r2_side[35] ? $signed({1'b0, r2_root}) : 35'(signed'(r2_side[34:1]));

	always_ff @(posedge clk) begin
		corner_region <= r2_side[35];
		if (res > 35'sd2147483647) begin
			distance  <= 32'sh7FFFFFFF;
			saturated <= 1'b1;
		end else if (res < -35'sd2147483648) begin
			distance  <= 32'sh80000000;
			saturated <= 1'b1;
		end else begin
			distance  <= res[31:0];
			saturated <= r2_side[0];
		end
	end

endmodule

### hw/rtl/csd_checker.sv
// Port-level checker for the cylinder distance top level, bound below.
// Depends on csd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csd_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic signed [csd_pkg::CoordW-1:0]  point_x,
	input logic signed [csd_pkg::CoordW-1:0]  point_y,
	input logic signed [csd_pkg::CoordW-1:0]  point_z,
	input logic                               done,
	input logic signed [csd_pkg::CoordW-1:0]  distance,
	input logic                               corner_region,
	input logic                               saturated,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [csd_pkg::IdxW-1:0]           cfg_index,
	input logic [csd_pkg::ColW-1:0]           cfg_data
);
	// Pipeline never holds off a transaction.
	`CSD_ASSERT_ALWAYS(a_never_busy, !busy && cfg_ready)
	// Corner distance is a root of a positive sum, so strictly positive.
	`CSD_ASSERT_IMPL(a_corner_pos, done && corner_region, distance > 0)
	// A negative distance only comes from the larger excess, never the corner path.
	`CSD_ASSERT_IMPL(a_neg_no_corner, done && distance[31], !corner_region)

endmodule

bind cylinder_signed_distance_top csd_checker u_csd_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for cylinder_signed_distance_top.
// Drives query points and register writes; a local predictor checks every result.
// Depends on csd_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic signed [31:0] dvalue;
		logic               corner;
		logic               sat;
	} csd_result_t;

	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles   = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic              done;
	logic signed [31:0] distance;
	logic              corner_region, saturated;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [csd_pkg::IdxW-1:0] cfg_index = '0;
	logic [csd_pkg::ColW-1:0] cfg_data = '0;

	logic [csd_pkg::ColW-1:0] shadow_regs [8];
	csd_result_t       pending_dist [$];
	int                mismatches = 0;
	int                idle_pct = 0;
	int                quiet_cycles = 0;

	cylinder_signed_distance_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned isqrt_rnd(longint unsigned s);
		longint unsigned r, b, v;
		r = 0;
		b = 64'd1 << 62;
		v = s;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (s - r * r > r) r = r + 1;
		return r;
	endfunction

	function automatic longint clamp32(longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint rotate_axis(longint d0, longint d1, longint d2,
			logic [csd_pkg::ColW-1:0] col, inout bit sat);
		longint acc;
		acc = d0 * longint'($signed(col[17:0])) + d1 * longint'($signed(col[35:18]))
			+ d2 * longint'($signed(col[53:36]));
		return clamp32((acc + 32768) >>> 16, sat);
	endfunction

	function automatic csd_result_t cylinder_distance(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		csd_result_t r;
		bit sat;
		longint d0, d1, d2, lx, ly, lz, dr, dz, az, res;
		longint unsigned rxy, half;
		sat = 1'b0;
		d0 = longint'(px) - longint'($signed(shadow_regs[csd_pkg::REG_CENTRE_X][31:0]));
		d1 = longint'(py) - longint'($signed(shadow_regs[csd_pkg::REG_CENTRE_Y][31:0]));
		d2 = longint'(pz) - longint'($signed(shadow_regs[csd_pkg::REG_CENTRE_Z][31:0]));
		lx = rotate_axis(d0, d1, d2, shadow_regs[csd_pkg::REG_AXIS_COL_X], sat);
		ly = rotate_axis(d0, d1, d2, shadow_regs[csd_pkg::REG_AXIS_COL_Y], sat);
		lz = rotate_axis(d0, d1, d2, shadow_regs[csd_pkg::REG_AXIS_COL_Z], sat);
		rxy = isqrt_rnd(longint'(lx * lx) + longint'(ly * ly));
		half = longint'(shadow_regs[csd_pkg::REG_CYL_HEIGHT][30:0]) >> 1;
		dr = longint'(rxy) - longint'(shadow_regs[csd_pkg::REG_CYL_RADIUS][30:0]);
		az = lz < 0 ? -lz : lz;
		dz = az - longint'(half);
		r.corner = (dr > 0 && dz > 0);
		if (r.corner)
			res = longint'(isqrt_rnd(dr * dr + dz * dz));
		else
			res = dr > dz ? dr : dz;
		res = clamp32(res, sat);
		r.dvalue = res[31:0];
		r.sat = sat;
		return r;
	endfunction

	task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		point_x = px;
		point_y = py;
		point_z = pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_dist = {pending_dist, cylinder_distance(px, py, pz)};
		@(negedge clk);
	endtask

	task automatic stop_points();
		start = 1'b0;
		while (pending_dist.size() != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(csd_pkg::reg_idx_t idx, logic [csd_pkg::ColW-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			csd_pkg::REG_AXIS_COL_X, csd_pkg::REG_AXIS_COL_Y, csd_pkg::REG_AXIS_COL_Z:
				shadow_regs[idx] = data;
			csd_pkg::REG_CYL_RADIUS, csd_pkg::REG_CYL_HEIGHT:
				shadow_regs[idx] = {23'd0, data[30:0]};
			default: shadow_regs[idx] = {22'd0, data[31:0]};
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [csd_pkg::ColW-1:0] pack_col(int e0, int e1, int e2);
		logic [17:0] a, b, c;
		a = e0[17:0];
		b = e1[17:0];
		c = e2[17:0];
		return {c, b, a};
	endfunction

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		if ($urandom_range(3) == 0) return $urandom;
		v = $urandom_range((1 << $urandom_range(8, 20)) - 1);
		return $urandom_range(1) ? -v : v;
	endfunction

	// entries either near the unit range or across the full Q2.16 range
	function automatic logic [csd_pkg::ColW-1:0] rand_col();
		int e [3];
		foreach (e[i]) e[i] = $urandom_range(1) ? $urandom_range(131071) - 65536
			: $urandom_range(262143) - 131072;
		return pack_col(e[0], e[1], e[2]);
	endfunction

	task automatic load_identity(logic [30:0] radius, logic [30:0] height);
		write_reg(csd_pkg::REG_CENTRE_X, 54'd0);
		write_reg(csd_pkg::REG_CENTRE_Y, 54'd0);
		write_reg(csd_pkg::REG_CENTRE_Z, 54'd0);
		write_reg(csd_pkg::REG_AXIS_COL_X, csd_pkg::ColXReset);
		write_reg(csd_pkg::REG_AXIS_COL_Y, csd_pkg::ColYReset);
		write_reg(csd_pkg::REG_AXIS_COL_Z, csd_pkg::ColZReset);
		write_reg(csd_pkg::REG_CYL_RADIUS, {23'h7fffff, radius});
		write_reg(csd_pkg::REG_CYL_HEIGHT, {23'd0, height});
	endtask

	task automatic test_directed();
		idle_pct = 0;
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sh10000, 32'sd0, 32'sd0);          // radial excess zero
		send_point(32'sd0, 32'sd0, 32'sh8000);           // axial excess zero
		send_point(32'sd0, 32'sd0, -32'sh8000);
		send_point(32'sh10000, 32'sd0, 32'sh8000);       // both zero
		send_point(32'sh20000, 32'sd0, 32'sh10000);      // corner
		send_point(-32'sh20000, 32'sh30000, -32'sh18000);
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sd0);
		send_point(32'sd0, 32'sd0, 32'sh80000000);
		send_point(32'sh00018000, -32'sh00001, 32'sh0000ffff);
		stop_points();
	endtask

	task automatic test_config_extremes();
		idle_pct = 0;
		load_identity(31'd0, 31'd0);
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sh100, 32'sd0, 32'sh100);
		stop_points();
		load_identity(31'h7fffffff, 31'h7fffffff);
		send_point(32'sd0, 32'sd0, 32'sd0);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		stop_points();
		write_reg(csd_pkg::REG_CENTRE_X, {22'h3fffff, 32'h7fffffff});
		write_reg(csd_pkg::REG_CENTRE_Y, 54'h80000000);
		write_reg(csd_pkg::REG_CENTRE_Z, 54'h80000000);
		write_reg(csd_pkg::REG_AXIS_COL_X, pack_col(-131072, -131072, -131072));
		write_reg(csd_pkg::REG_AXIS_COL_Y, pack_col(131071, 131071, 131071));
		write_reg(csd_pkg::REG_AXIS_COL_Z, pack_col(-131072, 131071, 0));
		write_reg(csd_pkg::REG_CYL_RADIUS, 54'd1);
		write_reg(csd_pkg::REG_CYL_HEIGHT, 54'd1);
		send_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
		send_point(32'sd0, 32'sd0, 32'sd0);
		stop_points();
	endtask

	// noise in the upper bits also checks that they are dropped
	task automatic test_random(int pct, int n);
		write_reg(csd_pkg::REG_CENTRE_X, {22'($urandom), rand_coord()});
		write_reg(csd_pkg::REG_CENTRE_Y, {22'($urandom), rand_coord()});
		write_reg(csd_pkg::REG_CENTRE_Z, {22'($urandom), rand_coord()});
		write_reg(csd_pkg::REG_AXIS_COL_X, rand_col());
		write_reg(csd_pkg::REG_AXIS_COL_Y, rand_col());
		write_reg(csd_pkg::REG_AXIS_COL_Z, rand_col());
		write_reg(csd_pkg::REG_CYL_RADIUS,
			{23'($urandom), 11'd0, 10'($urandom_range(1023)), 10'd0});
		write_reg(csd_pkg::REG_CYL_HEIGHT,
			{23'($urandom), 11'd0, 10'($urandom_range(1023)), 10'd0});
		idle_pct = pct;
		repeat (n) begin
			if ($urandom_range(7) == 0)
				send_point($urandom, $urandom, $urandom);
			else
				send_point($signed(shadow_regs[csd_pkg::REG_CENTRE_X][31:0]) + rand_coord(),
					$signed(shadow_regs[csd_pkg::REG_CENTRE_Y][31:0]) + rand_coord(),
					$signed(shadow_regs[csd_pkg::REG_CENTRE_Z][31:0]) + rand_coord());
		end
		stop_points();
	endtask

	always @(posedge clk) begin
		csd_result_t want;
		if (arst_n && done) begin
			if (pending_dist.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", distance);
			end else begin
				want = pending_dist.pop_front();
				if (want.dvalue !== distance || want.corner !== corner_region
						|| want.sat !== saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%b/%b got %h/%b/%b", want.dvalue,
							want.corner, want.sat, distance, corner_region, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		shadow_regs[csd_pkg::REG_CENTRE_X] = '0;
		shadow_regs[csd_pkg::REG_CENTRE_Y] = '0;
		shadow_regs[csd_pkg::REG_CENTRE_Z] = '0;
		shadow_regs[csd_pkg::REG_AXIS_COL_X] = csd_pkg::ColXReset;
		shadow_regs[csd_pkg::REG_AXIS_COL_Y] = csd_pkg::ColYReset;
		shadow_regs[csd_pkg::REG_AXIS_COL_Z] = csd_pkg::ColZReset;
		shadow_regs[csd_pkg::REG_CYL_RADIUS] = {23'd0, csd_pkg::LenReset};
		shadow_regs[csd_pkg::REG_CYL_HEIGHT] = {23'd0, csd_pkg::LenReset};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_config_extremes();
		test_random(0, 220);
		test_random(69, 200);
		test_random(37, 200);
		test_random(0, 120);
		test_random(69, 110);
		if (mismatches == 0 && pending_dist.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/csd_pkg.sv
hw/rtl/csd_sqrt.sv
hw/rtl/csd_xform.sv
hw/rtl/cylinder_signed_distance_top.sv
hw/rtl/csd_checker.sv
tb/tb_top.sv
